// File: sv/cra_pkg.sv
// cra_pkg: shared constants, types and helpers for the contiguous run allocator
// no dependencies; imported by every module of the block except cra_ram
`default_nettype none

package cra_pkg;

    localparam int MAX_SLOTS     = 1024;
    localparam int SLOT_W        = 10;
    localparam int CNT_W         = 11;
    localparam int REJ_W         = 32;
    localparam int WORD_BITS_DEF = 8;

    typedef enum logic [0:0] {
        REQ_ALLOC   = 1'b0,
        REQ_RELEASE = 1'b1
    } req_type_t;

    typedef enum logic [2:0] {
        ST_SWEEP,
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] start;
        logic [CNT_W-1:0]  run;
    } scan_res_t;

    typedef struct packed {
        logic              granted;
        logic [SLOT_W-1:0] start_slot;
        logic [REJ_W-1:0]  reject_total;
    } result_t;

    // clamp a written slot count into 1..MAX_SLOTS
    function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] v);
        logic [CNT_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = CNT_W'(1);
        end else if (v > CNT_W'(MAX_SLOTS)) begin
            r = CNT_W'(MAX_SLOTS);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: sv/contiguous_run_allocator_top.sv
// contiguous_run_allocator_top: first-fit allocator of runs over a row of slots
// depends on cra_pkg, cra_ram, cra_ctrl (which uses cra_word_scan)
//
//  channel  | ports                                        | transfer when
//  ---------+----------------------------------------------+------------------------
//  request  | s_valid s_ready s_req_type s_run_length      | s_valid && s_ready
//           | s_first_slot s_last_slot                     |
//  result   | m_valid m_ready m_granted m_start_slot       | m_valid && m_ready
//           | m_reject_total                               |
//  config   | cfg_wr_en cfg_wr_data (slot_count)           | cfg_wr_en, no wait
//
// slot state is a free bitmap in one ram, WORD_BITS slots per word, one request at a time
// allocate: each word is read and evaluated up to the fit, then each word of the run is
//   read and written back; a rejection scans every word, a zero length scans none
// release: each word in the range is read and written back; an empty range touches none
// after reset and after each slot_count write a sweep rewrites every word,
//   with s_ready low
// the result register lets a new request in while the last result waits on m_ready
`default_nettype none

module contiguous_run_allocator_top
    import cra_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // configuration
    input  wire logic              cfg_wr_en,
    input  wire logic [CNT_W-1:0]  cfg_wr_data,
    // request channel
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_req_type,
    input  wire logic [CNT_W-1:0]  s_run_length,
    input  wire logic [SLOT_W-1:0] s_first_slot,
    input  wire logic [SLOT_W-1:0] s_last_slot,
    // result channel
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic                   m_granted,
    output logic      [SLOT_W-1:0] m_start_slot,
    output logic      [REJ_W-1:0]  m_reject_total
);

    localparam int DEPTH  = MAX_SLOTS / WORD_BITS;
    localparam int ADDR_W = $clog2(DEPTH);

    // slot ram port
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [ADDR_W-1:0]    mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    // result hand-off from the sequencer
    logic    res_valid;
    logic    res_ready;
    result_t res;

    // output register
    logic    m_valid_reg, m_valid_next;
    result_t m_res_reg, m_res_next;

    // clamped slot count for the sequencer
    logic [CNT_W-1:0] cfg_count;

    assign cfg_count = sat_count(cfg_wr_data);

    cra_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    cra_ctrl #(
        .WORD_BITS (WORD_BITS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_wr_en),
        .cfg_count     (cfg_count),
        .in_valid      (s_valid),
        .in_ready      (s_ready),
        .in_req_type   (s_req_type),
        .in_run_length (s_run_length),
        .in_first_slot (s_first_slot),
        .in_last_slot  (s_last_slot),
        .res_valid     (res_valid),
        .res_ready     (res_ready),
        .res           (res),
        .mem_we        (mem_we),
        .mem_waddr     (mem_waddr),
        .mem_wdata     (mem_wdata),
        .mem_raddr     (mem_raddr),
        .mem_rdata     (mem_rdata)
    );

    // the output register takes a new result once the held one is gone or leaving
    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_res_next   = m_res_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_valid && res_ready) begin
            m_valid_next = 1'b1;
            m_res_next   = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        m_res_reg <= m_res_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_granted      = m_res_reg.granted;
    assign m_start_slot   = m_res_reg.start_slot;
    assign m_reject_total = m_res_reg.reject_total;

endmodule

`default_nettype wire

// File: sv/cra_ram.sv
// cra_ram: generic simple dual port ram, one write and one registered read port
// no dependencies
`default_nettype none

module cra_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: sv/cra_word_scan.sv
// cra_word_scan: extends the free run across one word of slot bits, finds first fit
// depends on cra_pkg
`default_nettype none

module cra_word_scan
    import cra_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic [SLOT_W-$clog2(WORD_BITS)-1:0] word_idx,
    input  wire logic [WORD_BITS-1:0]                free_bits,
    input  wire logic [CNT_W-1:0]                    run_in,
    input  wire logic [CNT_W-1:0]                    len,
    output scan_res_t                                res
);

    localparam int BIT_W = $clog2(WORD_BITS);

    logic [CNT_W-1:0]  run;
    logic              found;
    logic [SLOT_W-1:0] pos;
    logic [SLOT_W-1:0] start;

    always_comb begin
        run   = run_in;
        found = 1'b0;
        pos   = '0;
        start = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            run = free_bits[b] ? run + CNT_W'(1) : '0;
            if (!found && run >= len) begin
                found = 1'b1;
                pos   = {word_idx, BIT_W'(b)};
                start = SLOT_W'({1'b0, pos} + CNT_W'(1) - len);
            end
        end
        res.found = found;
        res.start = start;
        res.run   = run;
    end

endmodule

`default_nettype wire

// File: sv/cra_ctrl.sv
// cra_ctrl: sequencer for sweep, first-fit scan and range marking over the slot ram
// depends on cra_pkg and cra_word_scan
`default_nettype none

module cra_ctrl
    import cra_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_we,
    input  wire logic [CNT_W-1:0]                    cfg_count,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic                                in_req_type,
    input  wire logic [CNT_W-1:0]                    in_run_length,
    input  wire logic [SLOT_W-1:0]                   in_first_slot,
    input  wire logic [SLOT_W-1:0]                   in_last_slot,
    output logic                                     res_valid,
    input  wire logic                                res_ready,
    output result_t                                  res,
    output logic                                     mem_we,
    output logic      [SLOT_W-$clog2(WORD_BITS)-1:0] mem_waddr,
    output logic      [WORD_BITS-1:0]                mem_wdata,
    output logic      [SLOT_W-$clog2(WORD_BITS)-1:0] mem_raddr,
    input  wire logic [WORD_BITS-1:0]                mem_rdata
);

    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int ADDR_W = SLOT_W - BIT_W;
    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'((MAX_SLOTS / WORD_BITS) - 1);

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [CNT_W-1:0]  run_reg, run_next;
    logic [CNT_W-1:0]  len_reg, len_next;
    logic [SLOT_W-1:0] lo_reg, lo_next;
    logic [SLOT_W-1:0] hi_reg, hi_next;
    logic              fill_free_reg, fill_free_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [REJ_W-1:0]  reject_reg, reject_next;
    logic              granted_reg, granted_next;
    logic [SLOT_W-1:0] start_reg, start_next;

    scan_res_t         scan;
    logic              accept;
    logic [SLOT_W-1:0] last_clip;
    logic              rel_empty;
    logic              addr_is_hi;
    logic [WORD_BITS-1:0] sweep_word;
    logic [WORD_BITS-1:0] mark_word;
    logic [SLOT_W-1:0]    pos;

    cra_word_scan #(.WORD_BITS(WORD_BITS)) u_scan (
        .word_idx  (addr_reg),
        .free_bits (mem_rdata),
        .run_in    (run_reg),
        .len       (len_reg),
        .res       (scan)
    );

    assign accept     = in_valid && in_ready;
    assign last_clip  = ({1'b0, in_last_slot} >= count_reg) ?
                        SLOT_W'(count_reg - CNT_W'(1)) : in_last_slot;
    assign rel_empty  = in_first_slot > last_clip;
    assign addr_is_hi = addr_reg == hi_reg[SLOT_W-1:BIT_W];

    // word contents for sweep and for range marking
    always_comb begin
        sweep_word = '0;
        mark_word  = mem_rdata;
        pos        = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            pos           = {addr_reg, BIT_W'(b)};
            sweep_word[b] = {1'b0, pos} < count_reg;
            if (pos >= lo_reg && pos <= hi_reg) begin
                mark_word[b] = fill_free_reg;
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SWEEP: begin
                if (addr_reg == LAST_WORD) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (in_req_type == REQ_ALLOC) begin
                        state_next = (in_run_length == '0) ? ST_FINISH : ST_SCAN_RD;
                    end else begin
                        state_next = rel_empty ? ST_FINISH : ST_MARK_RD;
                    end
                end
            end
            ST_SCAN_RD: state_next = ST_SCAN_EV;
            ST_SCAN_EV: begin
                if (scan.found) begin
                    state_next = ST_MARK_RD;
                end else if (addr_reg == LAST_WORD) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_MARK_RD: state_next = ST_MARK_WR;
            ST_MARK_WR: begin
                if (addr_is_hi) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_MARK_RD;
                end
            end
            ST_FINISH: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cfg_we) begin
            state_next = ST_SWEEP;
        end
    end

    // datapath and outputs
    always_comb begin
        addr_next      = addr_reg;
        run_next       = run_reg;
        len_next       = len_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        fill_free_next = fill_free_reg;
        count_next     = count_reg;
        reject_next    = reject_reg;
        granted_next   = granted_reg;
        start_next     = start_reg;
        in_ready       = 1'b0;
        res_valid      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = addr_reg;
        mem_wdata      = mark_word;
        mem_raddr      = addr_reg;
        unique case (state_reg)
            ST_SWEEP: begin
                mem_we    = 1'b1;
                mem_wdata = sweep_word;
                addr_next = addr_reg + ADDR_W'(1);
            end
            ST_IDLE: begin
                in_ready = 1'b1;
                if (accept) begin
                    granted_next = 1'b1;
                    start_next   = '0;
                    len_next     = in_run_length;
                    run_next     = '0;
                    if (in_req_type == REQ_ALLOC) begin
                        addr_next = '0;
                    end else begin
                        lo_next        = in_first_slot;
                        hi_next        = last_clip;
                        fill_free_next = 1'b1;
                        addr_next      = in_first_slot[SLOT_W-1:BIT_W];
                    end
                end
            end
            ST_SCAN_RD: begin
            end
            ST_SCAN_EV: begin
                if (scan.found) begin
                    start_next     = scan.start;
                    lo_next        = scan.start;
                    hi_next        = SLOT_W'({1'b0, scan.start} + len_reg - CNT_W'(1));
                    fill_free_next = 1'b0;
                    addr_next      = scan.start[SLOT_W-1:BIT_W];
                end else if (addr_reg == LAST_WORD) begin
                    granted_next = 1'b0;
                    if (reject_reg != '1) begin
                        reject_next = reject_reg + REJ_W'(1);
                    end
                end else begin
                    run_next  = scan.run;
                    addr_next = addr_reg + ADDR_W'(1);
                end
            end
            ST_MARK_RD: begin
            end
            ST_MARK_WR: begin
                mem_we    = 1'b1;
                addr_next = addr_reg + ADDR_W'(1);
            end
            ST_FINISH: begin
                res_valid = 1'b1;
            end
            default: begin
            end
        endcase
        if (cfg_we) begin
            count_next = cfg_count;
            addr_next  = '0;
        end
    end

    assign res.granted      = granted_reg;
    assign res.start_slot   = start_reg;
    assign res.reject_total = reject_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_SWEEP;
            addr_reg   <= '0;
            count_reg  <= CNT_W'(MAX_SLOTS);
            reject_reg <= '0;
        end else begin
            state_reg  <= state_next;
            addr_reg   <= addr_next;
            count_reg  <= count_next;
            reject_reg <= reject_next;
        end
        run_reg       <= run_next;
        len_reg       <= len_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        fill_free_reg <= fill_free_next;
        granted_reg   <= granted_next;
        start_reg     <= start_next;
    end

    a_scan_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN_RD || state_reg == ST_SCAN_EV) |-> !mem_we)
        else $error("slot ram written during scan");

    a_reject_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) |-> reject_reg >= $past(reject_reg))
        else $error("reject counter went down");

    a_mark_range_order: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MARK_WR |-> lo_reg <= hi_reg)
        else $error("marking an inverted range");

    a_mark_addr_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_MARK_WR |->
            (addr_reg >= lo_reg[SLOT_W-1:BIT_W] && addr_reg <= hi_reg[SLOT_W-1:BIT_W]))
        else $error("mark word outside range");

    a_grant_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN_EV && scan.found && !cfg_we) |=> $stable(reject_reg))
        else $error("reject counter moved on a grant");

endmodule

`default_nettype wire
